// File: rtl/vau_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vau_pkg
// Shared types, codes and helpers of the fixed-point vector arithmetic unit.
// -----------------------------------------------------------------------------
package vau_pkg;

   localparam int WORD_BITS   = 32;
   localparam int FRAC_BITS   = 16;
   localparam int ROOT_STAGES = WORD_BITS;
   localparam int QUOT_BITS   = FRAC_BITS + 1;

   localparam logic signed [65:0] SMAX_WIDE = 66'sd2147483647;
   localparam logic signed [65:0] SMIN_WIDE = -66'sd2147483648;
   localparam logic signed [31:0] SMAX_WORD = 32'sh7fff_ffff;

   typedef enum logic [3:0] {
      OP_ADD       = 4'd0,
      OP_SUB       = 4'd1,
      OP_SCALE     = 4'd2,
      OP_DOT       = 4'd3,
      OP_CROSS     = 4'd4,
      OP_LENGTH    = 4'd5,
      OP_NORMALIZE = 4'd6,
      OP_DISTANCE  = 4'd7,
      OP_EQUALS    = 4'd8,
      OP_COLINEAR  = 4'd9,
      OP_OPPOSITE  = 4'd10
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ZERO_LEN  = 2'd1,
      ST_SATURATED = 2'd2
   } status_type;

   typedef logic signed [31:0] word_type;

   typedef struct packed {
      word_type   res_x;
      word_type   res_y;
      word_type   res_z;
      word_type   scalar;
      logic       flag;
      status_type status;
   } res_type;

   // per-component lane results after the multiplier stage
   typedef struct packed {
      logic signed [32:0] addsub;
      logic               big;
      logic               eq;
      logic signed [63:0] p0;
      logic signed [63:0] p1;
      logic [31:0]        mag_a;
      logic [31:0]        mag_b;
      logic               neg_a;
      logic               neg_b;
   } lane_type;

   // request context riding along the square root stages
   typedef struct packed {
      op_type          op;
      res_type         fast;
      logic            big;
      logic [2:0][31:0] mag_a;
      logic [2:0][31:0] mag_b;
      logic [2:0]      neg_a;
      logic [2:0]      neg_b;
   } ctx_type;

   // request context riding along the divider stages
   typedef struct packed {
      op_type      op;
      res_type     fast;
      logic        big;
      logic [31:0] root_a;
      logic [31:0] root_b;
      logic [2:0]  neg_a;
      logic [2:0]  neg_b;
   } tail_type;

   typedef struct packed {
      word_type value;
      logic     hit;
   } sat_type;

   // clamp a wide signed value to the word range
   function automatic sat_type sat_word(input logic signed [65:0] v);
      sat_type r;
      r.hit   = 1'b0;
      r.value = v[31:0];
      if (v > SMAX_WIDE) begin
         r.value = SMAX_WIDE[31:0];
         r.hit   = 1'b1;
      end else if (v < SMIN_WIDE) begin
         r.value = SMIN_WIDE[31:0];
         r.hit   = 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/vau_lane.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vau_lane
// One vector component: operand selection, add/sub, and two 32x32 products.
// -----------------------------------------------------------------------------
module vau_lane import vau_pkg::*; (
   input  wire logic     clock,
   input  wire op_type   op,
   input  wire word_type a_i,
   input  wire word_type b_i,
   input  wire word_type a_j,
   input  wire word_type b_j,
   input  wire word_type a_k,
   input  wire word_type b_k,
   input  wire word_type factor,
   output lane_type      lane
);

   logic signed [32:0] sum_w, diff_w, addsub_in, addsub_ff, addsub2_ff;
   word_type           m0a_in, m0b_in, m1a_in, m1b_in;
   word_type           m0a_ff, m0b_ff, m1a_ff, m1b_ff;
   logic               big_in, big_ff, big2_ff, eq_ff, eq2_ff;
   logic [31:0]        mag_a_ff, mag_b_ff, mag_a2_ff, mag_b2_ff;
   logic               neg_a_ff, neg_b_ff, neg_a2_ff, neg_b2_ff;
   logic signed [63:0] p0_ff, p1_ff;

   assign sum_w  = {a_i[31], a_i} + {b_i[31], b_i};
   assign diff_w = {a_i[31], a_i} - {b_i[31], b_i};

   // pick multiplier operands for the operation
   always_comb begin
      m0a_in    = a_i;
      m0b_in    = a_i;
      m1a_in    = '0;
      m1b_in    = '0;
      addsub_in = sum_w;
      big_in    = 1'b0;
      unique case (op)
         OP_SUB: addsub_in = diff_w;
         OP_SCALE: m0b_in = factor;
         OP_DOT: m0b_in = b_i;
         OP_CROSS: begin
            m0a_in = a_j;
            m0b_in = b_k;
            m1a_in = a_k;
            m1b_in = b_j;
         end
         OP_DISTANCE: begin
            addsub_in = diff_w;
            m0a_in    = diff_w[31:0];
            m0b_in    = diff_w[31:0];
            big_in    = (diff_w > 33'sd2147483647) || (diff_w < -33'sd2147483647);
         end
         OP_COLINEAR, OP_OPPOSITE: begin
            m1a_in = b_i;
            m1b_in = b_i;
         end
         default: begin
         end
      endcase
   end

   // register operands
   always_ff @(posedge clock) begin
      m0a_ff    <= m0a_in;
      m0b_ff    <= m0b_in;
      m1a_ff    <= m1a_in;
      m1b_ff    <= m1b_in;
      addsub_ff <= addsub_in;
      big_ff    <= big_in;
      eq_ff     <= (a_i == b_i);
      neg_a_ff  <= a_i[31];
      neg_b_ff  <= b_i[31];
      mag_a_ff  <= a_i[31] ? 32'(-a_i) : 32'(a_i);
      mag_b_ff  <= b_i[31] ? 32'(-b_i) : 32'(b_i);
   end

   // multiply
   always_ff @(posedge clock) begin
      p0_ff      <= m0a_ff * m0b_ff;
      p1_ff      <= m1a_ff * m1b_ff;
      addsub2_ff <= addsub_ff;
      big2_ff    <= big_ff;
      eq2_ff     <= eq_ff;
      neg_a2_ff  <= neg_a_ff;
      neg_b2_ff  <= neg_b_ff;
      mag_a2_ff  <= mag_a_ff;
      mag_b2_ff  <= mag_b_ff;
   end

   assign lane.addsub = addsub2_ff;
   assign lane.big    = big2_ff;
   assign lane.eq     = eq2_ff;
   assign lane.p0     = p0_ff;
   assign lane.p1     = p1_ff;
   assign lane.mag_a  = mag_a2_ff;
   assign lane.mag_b  = mag_b2_ff;
   assign lane.neg_a  = neg_a2_ff;
   assign lane.neg_b  = neg_b2_ff;

endmodule
`default_nettype wire

// File: rtl/vau_sqrt.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vau_sqrt
// Pipelined integer square root, rounded down, one root bit per stage.
// -----------------------------------------------------------------------------
module vau_sqrt import vau_pkg::*; (
   input  wire logic        clock,
   input  wire logic [63:0] radicand,
   output logic [31:0]      root
);

   localparam int LAST = ROOT_STAGES - 1;

   logic [33:0] rem_ff  [LAST];
   logic [63:0] rad_ff  [LAST];
   logic [31:0] root_ff [ROOT_STAGES];

   for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
      logic [33:0] rem_prev;
      logic [63:0] rad_prev;
      logic [31:0] root_prev;
      logic [35:0] cur, trial;
      logic        take;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign rad_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      assign cur   = {rem_prev, rad_prev[63:62]};
      assign trial = {2'b00, root_prev, 2'b01};
      assign take  = (cur >= trial);

      // settle one root bit
      always_ff @(posedge clock) begin
         root_ff[k] <= {root_prev[30:0], take};
      end

      if (k < LAST) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k] <= take ? 34'(cur - trial) : cur[33:0];
            rad_ff[k] <= {rad_prev[61:0], 2'b00};
         end
      end
   end

   assign root = root_ff[LAST];

endmodule
`default_nettype wire

// File: rtl/vau_div.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vau_div
// Pipelined restoring divider: floor(mag * 2^FRAC_BITS / divisor), one bit a stage.
// Assumes mag <= divisor, so the quotient fits FRAC_BITS+1 bits.
// -----------------------------------------------------------------------------
module vau_div import vau_pkg::*; (
   input  wire logic        clock,
   input  wire logic [31:0] mag,
   input  wire logic [31:0] divisor,
   output logic [QUOT_BITS-1:0] quotient
);

   localparam int LAST = QUOT_BITS - 1;

   logic [31:0]          rem_ff [LAST];
   logic [31:0]          div_ff [LAST];
   logic [QUOT_BITS-1:0] q_ff   [QUOT_BITS];

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
      logic [31:0]          rem_prev, div_prev;
      logic [QUOT_BITS-1:0] q_prev;
      logic                 nbit;
      logic [32:0]          cur;
      logic                 take;

      if (k == 0) begin : g_first
         assign rem_prev = {1'b0, mag[31:1]};
         assign div_prev = divisor;
         assign q_prev   = '0;
         assign nbit     = mag[0];
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign div_prev = div_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign nbit     = 1'b0;
      end

      assign cur  = {rem_prev, nbit};
      assign take = (cur >= {1'b0, div_prev});

      // settle one quotient bit
      always_ff @(posedge clock) begin
         q_ff[k] <= {q_prev[QUOT_BITS-2:0], take};
      end

      if (k < LAST) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k] <= take ? 32'(cur - {1'b0, div_prev}) : cur[31:0];
            div_ff[k] <= div_prev;
         end
      end
   end

   assign quotient = q_ff[LAST];

endmodule
`default_nettype wire

// File: rtl/vector3_arithmetic_unit.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vector3_arithmetic_unit
// Q16.16 three-dimensional vector ALU: add, sub, scale, dot, cross, length,
// normalize, distance, equals, colinear, opposite.
//
// A request is taken at each rising edge where start is high and busy is low.
// busy never rises: a new request may be issued every cycle.
// Each request yields one response, shown for exactly one cycle with rsp_valid
// high; the response is accepted at the edge that ends that cycle, and there
// is no way to hold it off.
// From the accepting edge the request passes, in order, the input register,
// operand stage, multiplier, merge, 32 square root stages, 17 divider stages
// and output register, and rsp_valid is high while the output register holds it;
// the input register loads at the accepting edge itself. Every operation takes the full
// path so responses leave in request order.
// Throughput is one request per cycle, set by the fully pipelined square root
// and divider units.
// Reset clears the valid line; requests in flight are dropped.
// -----------------------------------------------------------------------------
module vector3_arithmetic_unit import vau_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_operation,
   input  wire logic signed [31:0] req_a_x,
   input  wire logic signed [31:0] req_a_y,
   input  wire logic signed [31:0] req_a_z,
   input  wire logic signed [31:0] req_b_x,
   input  wire logic signed [31:0] req_b_y,
   input  wire logic signed [31:0] req_b_z,
   input  wire logic signed [31:0] req_factor,
   output logic             rsp_valid,
   output logic signed [31:0] rsp_res_x,
   output logic signed [31:0] rsp_res_y,
   output logic signed [31:0] rsp_res_z,
   output logic signed [31:0] rsp_res_scalar,
   output logic             rsp_res_flag,
   output logic [1:0]       rsp_status
);

   localparam int VALID_STAGES = 4 + ROOT_STAGES + QUOT_BITS + 1;

   logic [VALID_STAGES-1:0] vld_ff;
   op_type                  op_s0_ff, op_s1_ff, op_s2_ff;
   word_type                a_ff [3];
   word_type                b_ff [3];
   word_type                fac_ff;
   lane_type                lanes [3];
   ctx_type                 ctx_in;
   ctx_type                 ctx_ff [ROOT_STAGES+1];
   logic [63:0]             sq_a_in, sq_b_in, sq_a_ff, sq_b_ff;
   logic [31:0]             root_a, root_b;
   tail_type                tail_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0]    qa [3];
   logic [QUOT_BITS-1:0]    qb [3];
   res_type                 out_in, out_ff;

   assign busy = 1'b0;

   // track requests in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[VALID_STAGES-2:0], start & ~busy};
      end
   end

   // capture the request
   always_ff @(posedge clock) begin
      op_s0_ff <= op_type'(req_operation);
      a_ff[0]  <= req_a_x;
      a_ff[1]  <= req_a_y;
      a_ff[2]  <= req_a_z;
      b_ff[0]  <= req_b_x;
      b_ff[1]  <= req_b_y;
      b_ff[2]  <= req_b_z;
      fac_ff   <= req_factor;
      op_s1_ff <= op_s0_ff;
      op_s2_ff <= op_s1_ff;
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      vau_lane u_lane (
         .clock  (clock),
         .op     (op_s0_ff),
         .a_i    (a_ff[i]),
         .b_i    (b_ff[i]),
         .a_j    (a_ff[(i+1)%3]),
         .b_j    (b_ff[(i+1)%3]),
         .a_k    (a_ff[(i+2)%3]),
         .b_k    (b_ff[(i+2)%3]),
         .factor (fac_ff),
         .lane   (lanes[i])
      );
   end

   // merge lanes: direct results and sums of squares
   always_comb begin : merge
      sat_type            s;
      logic               hit;
      word_type           comp [3];
      logic signed [65:0] wide0 [3];
      logic signed [65:0] wide1 [3];
      logic signed [65:0] dot_sum;
      hit = 1'b0;
      s   = '0;
      for (int i = 0; i < 3; i++) begin
         comp[i]  = '0;
         wide0[i] = {{2{lanes[i].p0[63]}}, lanes[i].p0};
         wide1[i] = {{2{lanes[i].p1[63]}}, lanes[i].p1};
      end
      dot_sum = wide0[0] + wide0[1] + wide0[2];
      ctx_in  = '0;
      ctx_in.op = op_s2_ff;
      unique case (op_s2_ff)
         OP_ADD, OP_SUB: begin
            for (int i = 0; i < 3; i++) begin
               s       = sat_word({{33{lanes[i].addsub[32]}}, lanes[i].addsub});
               comp[i] = s.value;
               hit     = hit | s.hit;
            end
         end
         OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               s       = sat_word(wide0[i] >>> FRAC_BITS);
               comp[i] = s.value;
               hit     = hit | s.hit;
            end
         end
         OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               s       = sat_word((wide0[i] - wide1[i]) >>> FRAC_BITS);
               comp[i] = s.value;
               hit     = hit | s.hit;
            end
         end
         OP_DOT: begin
            s                = sat_word(dot_sum >>> FRAC_BITS);
            ctx_in.fast.scalar = s.value;
            hit              = s.hit;
         end
         OP_EQUALS: ctx_in.fast.flag = lanes[0].eq & lanes[1].eq & lanes[2].eq;
         default: begin
         end
      endcase
      ctx_in.fast.res_x  = comp[0];
      ctx_in.fast.res_y  = comp[1];
      ctx_in.fast.res_z  = comp[2];
      ctx_in.fast.status = hit ? ST_SATURATED : ST_OK;
      ctx_in.big = lanes[0].big | lanes[1].big | lanes[2].big;
      for (int i = 0; i < 3; i++) begin
         ctx_in.mag_a[i] = lanes[i].mag_a;
         ctx_in.mag_b[i] = lanes[i].mag_b;
         ctx_in.neg_a[i] = lanes[i].neg_a;
         ctx_in.neg_b[i] = lanes[i].neg_b;
      end
      sq_a_in = $unsigned(lanes[0].p0) + $unsigned(lanes[1].p0) + $unsigned(lanes[2].p0);
      sq_b_in = $unsigned(lanes[0].p1) + $unsigned(lanes[1].p1) + $unsigned(lanes[2].p1);
   end

   always_ff @(posedge clock) begin
      ctx_ff[0] <= ctx_in;
      sq_a_ff   <= sq_a_in;
      sq_b_ff   <= sq_b_in;
   end

   vau_sqrt u_sqrt_a (.clock(clock), .radicand(sq_a_ff), .root(root_a));
   vau_sqrt u_sqrt_b (.clock(clock), .radicand(sq_b_ff), .root(root_b));

   // carry the context beside the root stages
   for (genvar k = 1; k <= ROOT_STAGES; k++) begin : g_ctx
      always_ff @(posedge clock) begin
         ctx_ff[k] <= ctx_ff[k-1];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_div
      vau_div u_div_a (
         .clock(clock), .mag(ctx_ff[ROOT_STAGES].mag_a[i]), .divisor(root_a),
         .quotient(qa[i])
      );
      vau_div u_div_b (
         .clock(clock), .mag(ctx_ff[ROOT_STAGES].mag_b[i]), .divisor(root_b),
         .quotient(qb[i])
      );
   end

   // carry the context beside the divider stages
   always_ff @(posedge clock) begin
      tail_ff[0].op     <= ctx_ff[ROOT_STAGES].op;
      tail_ff[0].fast   <= ctx_ff[ROOT_STAGES].fast;
      tail_ff[0].big    <= ctx_ff[ROOT_STAGES].big;
      tail_ff[0].root_a <= root_a;
      tail_ff[0].root_b <= root_b;
      tail_ff[0].neg_a  <= ctx_ff[ROOT_STAGES].neg_a;
      tail_ff[0].neg_b  <= ctx_ff[ROOT_STAGES].neg_b;
   end

   for (genvar k = 1; k < QUOT_BITS; k++) begin : g_tail
      always_ff @(posedge clock) begin
         tail_ff[k] <= tail_ff[k-1];
      end
   end

   // select the final response
   always_comb begin : finish
      tail_type           t;
      logic signed [17:0] na [3];
      logic signed [17:0] nb [3];
      logic               same, opp;
      t = tail_ff[QUOT_BITS-1];
      for (int i = 0; i < 3; i++) begin
         na[i] = t.neg_a[i] ? -$signed({1'b0, qa[i]}) : $signed({1'b0, qa[i]});
         nb[i] = t.neg_b[i] ? -$signed({1'b0, qb[i]}) : $signed({1'b0, qb[i]});
      end
      same = (na[0] == nb[0]) && (na[1] == nb[1]) && (na[2] == nb[2]);
      opp  = (na[0] == -nb[0]) && (na[1] == -nb[1]) && (na[2] == -nb[2]);
      out_in = '0;
      unique case (t.op)
         OP_LENGTH, OP_DISTANCE: begin
            if (t.big || t.root_a[31]) begin
               out_in.scalar = SMAX_WORD;
               out_in.status = ST_SATURATED;
            end else begin
               out_in.scalar = $signed(t.root_a);
            end
         end
         OP_NORMALIZE: begin
            if (t.root_a == '0) begin
               out_in.status = ST_ZERO_LEN;
            end else begin
               out_in.res_x = 32'(na[0]);
               out_in.res_y = 32'(na[1]);
               out_in.res_z = 32'(na[2]);
            end
         end
         OP_COLINEAR, OP_OPPOSITE: begin
            if (t.root_a == '0 || t.root_b == '0) begin
               out_in.status = ST_ZERO_LEN;
            end else begin
               out_in.flag = (t.op == OP_COLINEAR) ? (same | opp) : opp;
            end
         end
         default: out_in = t.fast;
      endcase
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid      = vld_ff[VALID_STAGES-1];
   assign rsp_res_x      = out_ff.res_x;
   assign rsp_res_y      = out_ff.res_y;
   assign rsp_res_z      = out_ff.res_z;
   assign rsp_res_scalar = out_ff.scalar;
   assign rsp_res_flag   = out_ff.flag;
   assign rsp_status     = out_ff.status;

   // checks
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3)) else $error("undefined status code");

   a_flag_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_res_flag) |-> (rsp_status == ST_OK))
      else $error("flag set with nonzero status");

   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_ZERO_LEN) |->
         (rsp_res_x == '0 && rsp_res_y == '0 && rsp_res_z == '0 && !rsp_res_flag))
      else $error("zero length response carries data");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> ##(VALID_STAGES-1) rsp_valid) else $error("response lost");

endmodule
`default_nettype wire
